>>> rtl/core/smas_pkg.sv
// ----------------------------------------------------------------------------
// smas_pkg: shared types and constants of the sparse matrix add/sub block
// Request codes, field widths, parameter defaults and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package smas_pkg;

	localparam int CAPACITY_DEF    = 8;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int REQ_W   = 3;
	localparam int POS_W   = 16;
	localparam int VALUE_W = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_A = 3'd0,
		REQ_LOAD_B = 3'd1,
		REQ_SUM    = 3'd2,
		REQ_DIFF   = 3'd3,
		REQ_CLEAR  = 3'd4
	} smas_req_t;

	// Source of an entry pushed into the result stream.
	typedef enum logic [1:0] {
		SRC_SUM = 2'd0,
		SRC_A   = 2'd1,
		SRC_B   = 2'd2
	} smas_src_t;

	typedef struct packed {
		logic      start;
		logic      diff;
		logic      load_a;
		logic      load_b;
		logic      clear_lists;
		logic      adv_a;
		logic      adv_b;
		logic      push;
		smas_src_t src;
		logic      flush;
	} smas_cmd_t;

	typedef struct packed {
		logic match;
		logic hit;
		logic b_hit;
		logic i_end;
		logic j_end;
		logic na_zero;
		logic nb_zero;
		logic can_push;
		logic obuf_free;
	} smas_stat_t;

endpackage

>>> rtl/core/smas_if.sv
// ----------------------------------------------------------------------------
// smas_if: stream channels of the sparse matrix add/sub block
// One request channel and one result channel, each a valid/ready handshake
// that moves one word when both are high at a rising clock edge.
// ----------------------------------------------------------------------------
interface smas_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [smas_pkg::REQ_W-1:0]            req_type;
	logic [smas_pkg::POS_W-1:0]            entry_pos;
	logic signed [smas_pkg::VALUE_W-1:0]   entry_value;

	modport source (output valid, output req_type, output entry_pos,
		output entry_value, input ready);
	modport sink (input valid, input req_type, input entry_pos,
		input entry_value, output ready);
endinterface

interface smas_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [smas_pkg::POS_W-1:0]            out_pos;
	logic signed [smas_pkg::VALUE_W-1:0]   out_value;
	logic                                  out_valid;
	logic                                  out_last;

	modport source (output valid, output out_pos, output out_value,
		output out_valid, output out_last, input ready);
	modport sink (input valid, input out_pos, input out_value,
		input out_valid, input out_last, output ready);
endinterface

>>> rtl/core/smas_ctrl.sv
// ----------------------------------------------------------------------------
// smas_ctrl: request decoder and merge sequencer
// Takes request words while idle and steps the datapath through the scan of
// list A against list B, the scan of unmatched B entries and the final flush.
// ----------------------------------------------------------------------------
module smas_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [smas_pkg::REQ_W-1:0] req_type,
	output logic                       req_ready,
	input  smas_pkg::smas_stat_t       st,
	output smas_pkg::smas_cmd_t        cmd
);
	import smas_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN_A = 4'b0010,
		ST_SCAN_B = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   push_sum, push_a;

	assign req_ready = (state_q == ST_IDLE);
	assign push_sum  = st.match;
	assign push_a    = st.j_end && !st.match && !st.hit;

	always_comb begin
		cmd     = '0;
		cmd.src = SRC_A;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						REQ_LOAD_A: cmd.load_a = 1'b1;
						REQ_LOAD_B: cmd.load_b = 1'b1;
						REQ_SUM, REQ_DIFF: begin
							cmd.start = 1'b1;
							cmd.diff  = (req_type == REQ_DIFF);
							if (!st.na_zero)
								state_d = ST_SCAN_A;
							else if (!st.nb_zero)
								state_d = ST_SCAN_B;
							else
								state_d = ST_FLUSH;
						end
						REQ_CLEAR: cmd.clear_lists = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN_A: begin
				// One (A, B) pair per cycle unless a push must wait; at most one entry is pushed.
				if (!(push_sum || push_a) || st.can_push) begin
					cmd.adv_a = 1'b1;
					cmd.push  = push_sum || push_a;
					cmd.src   = push_sum ? SRC_SUM : SRC_A;
					if (st.j_end && st.i_end)
						state_d = st.nb_zero ? ST_FLUSH : ST_SCAN_B;
				end
			end
			ST_SCAN_B: begin
				if (st.b_hit || st.can_push) begin
					cmd.adv_b = 1'b1;
					cmd.push  = !st.b_hit;
					cmd.src   = SRC_B;
					if (st.j_end)
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (st.obuf_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");
	a_scan_b_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_B) |-> !st.nb_zero)
		else $error("scan of list B entered with list B empty");
	a_flush_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

endmodule

>>> rtl/core/smas_dp.sv
// ----------------------------------------------------------------------------
// smas_dp: entry lists, pair comparator, adder and result buffers
// Holds both lists and their counts, the scan indexes and match flags, one
// pending entry (so the final one can be tagged last) and the output register.
// ----------------------------------------------------------------------------
module smas_dp #(
	parameter int CAPACITY    = smas_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = smas_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  smas_pkg::smas_cmd_t                cmd,
	output smas_pkg::smas_stat_t               st,
	input  logic [smas_pkg::POS_W-1:0]         entry_pos,
	input  logic signed [smas_pkg::VALUE_W-1:0] entry_value,
	output logic                               word_valid,
	input  logic                               word_ready,
	output logic [smas_pkg::POS_W-1:0]         out_pos,
	output logic signed [smas_pkg::VALUE_W-1:0] out_value,
	output logic                               out_valid,
	output logic                               out_last
);
	import smas_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [POS_W-1:0]       a_pos_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] a_val_q [CAPACITY];
	logic [POS_W-1:0]       b_pos_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] b_val_q [CAPACITY];
	logic [CNT_W-1:0]       cnt_a_q, cnt_b_q;
	logic [IDX_W-1:0]       i_q, j_q;
	logic                   hit_q, diff_q;
	logic [CAPACITY-1:0]    bmatch_q;

	logic                   pend_v_q;
	logic [POS_W-1:0]       pend_pos_q;
	logic [VALUE_WIDTH-1:0] pend_val_q;
	logic                   obuf_v_q;

	logic [POS_W-1:0]       cur_a_pos, cur_b_pos, new_pos;
	logic [VALUE_WIDTH-1:0] cur_a_val, cur_b_val, new_val, pair_val;

	assign cur_a_pos = a_pos_q[i_q];
	assign cur_a_val = a_val_q[i_q];
	assign cur_b_pos = b_pos_q[j_q];
	assign cur_b_val = b_val_q[j_q];
	assign pair_val  = diff_q ? (cur_a_val - cur_b_val) : (cur_a_val + cur_b_val);

	always_comb begin
		case (cmd.src)
			SRC_SUM: begin
				new_pos = cur_a_pos;
				new_val = pair_val;
			end
			SRC_B: begin
				new_pos = cur_b_pos;
				new_val = diff_q ? (VALUE_WIDTH'(0) - cur_b_val) : cur_b_val;
			end
			default: begin
				new_pos = cur_a_pos;
				new_val = cur_a_val;
			end
		endcase
	end

	assign st.na_zero   = (cnt_a_q == '0);
	assign st.nb_zero   = (cnt_b_q == '0);
	assign st.match     = !st.nb_zero && (cur_a_pos == cur_b_pos);
	assign st.hit       = hit_q;
	assign st.b_hit     = bmatch_q[j_q];
	assign st.i_end     = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_a_q);
	assign st.j_end     = st.nb_zero || ((CNT_W'(j_q) + CNT_W'(1)) == cnt_b_q);
	assign st.obuf_free = !obuf_v_q || word_ready;
	assign st.can_push  = !pend_v_q || st.obuf_free;

	assign word_valid = obuf_v_q;

	// List storage: only entries below the counts are ever read.
	always_ff @(posedge clk) begin
		if (cmd.load_a && (cnt_a_q < CAP_CNT)) begin
			a_pos_q[cnt_a_q[IDX_W-1:0]] <= entry_pos;
			a_val_q[cnt_a_q[IDX_W-1:0]] <= entry_value[VALUE_WIDTH-1:0];
		end
		if (cmd.load_b && (cnt_b_q < CAP_CNT)) begin
			b_pos_q[cnt_b_q[IDX_W-1:0]] <= entry_pos;
			b_val_q[cnt_b_q[IDX_W-1:0]] <= entry_value[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			hit_q    <= 1'b0;
			diff_q   <= 1'b0;
			bmatch_q <= '0;
			pend_v_q <= 1'b0;
			obuf_v_q <= 1'b0;
		end else begin
			if (cmd.load_a && (cnt_a_q < CAP_CNT))
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			if (cmd.load_b && (cnt_b_q < CAP_CNT))
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			if (cmd.clear_lists) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end

			if (cmd.start) begin
				i_q      <= '0;
				j_q      <= '0;
				hit_q    <= 1'b0;
				diff_q   <= cmd.diff;
				bmatch_q <= '0;
			end
			if (cmd.adv_a) begin
				if (st.match)
					bmatch_q[j_q] <= 1'b1;
				if (st.j_end) begin
					j_q   <= '0;
					hit_q <= 1'b0;
					i_q   <= st.i_end ? '0 : i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
					if (st.match)
						hit_q <= 1'b1;
				end
			end
			if (cmd.adv_b)
				j_q <= j_q + IDX_W'(1);

			if (obuf_v_q && word_ready)
				obuf_v_q <= 1'b0;
			if (cmd.push) begin
				pend_v_q <= 1'b1;
				if (pend_v_q)
					obuf_v_q <= 1'b1;
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
				obuf_v_q <= 1'b1;
			end
		end
	end

	// Payload of the pending entry and the output register.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_pos_q <= new_pos;
			pend_val_q <= new_val;
			if (pend_v_q) begin
				out_pos   <= pend_pos_q;
				out_value <= VALUE_W'(signed'(pend_val_q));
				out_valid <= 1'b1;
				out_last  <= 1'b0;
			end
		end
		if (cmd.flush) begin
			out_last <= 1'b1;
			if (pend_v_q) begin
				out_pos   <= pend_pos_q;
				out_value <= VALUE_W'(signed'(pend_val_q));
				out_valid <= 1'b1;
			end else begin
				out_pos   <= '0;
				out_value <= '0;
				out_valid <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CAP_CNT) && (cnt_b_q <= CAP_CNT))
		else $error("list count beyond capacity");
	a_push_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && pend_v_q) |-> st.obuf_free)
		else $error("pending entry moved into a busy output register");
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (st.obuf_free && !cmd.push))
		else $error("flush into a busy output register");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(obuf_v_q && !out_valid) |-> out_last)
		else $error("empty result word not marked last");

endmodule

>>> rtl/core/sparse_matrix_add_sub.sv
// ----------------------------------------------------------------------------
// sparse_matrix_add_sub: add or subtract two sparse matrices in list form
// Top level: joins the merge sequencer and the list datapath to the request
// and result channels.
// ----------------------------------------------------------------------------
// The block keeps two lists, A and B, of up to CAPACITY (position, value)
// entries each, filled by load requests; a load into a full list is dropped
// and clear empties both lists. A sum or difference request streams the
// merged list: for each A entry in load order, one word per B entry at the
// same position carrying A+B or A-B, or the plain A value if there is none;
// then every B entry whose position appears nowhere in A, negated for a
// difference. Values wrap at VALUE_WIDTH bits and are sign-extended to 32.
// The final word of a list has out_last set; an emit with both lists empty
// gives a single word with out_valid low and out_last high. Loads, clears and
// unused codes produce no words. An emit walks every (A, B) pair through one
// position comparator and one adder, one pair per cycle, then the B list one
// entry per cycle; a step that pushes a word waits while the result channel
// stalls. One request is handled at a time: the request channel is ready
// whenever the sequencer is idle, and a finished result word may still be
// waiting in the output register while the next request is taken. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module sparse_matrix_add_sub #(
	parameter int CAPACITY    = smas_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = smas_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smas_in_if.sink     in_ch,
	smas_out_if.source  out_ch
);
	import smas_pkg::*;

	smas_cmd_t  cmd;
	smas_stat_t st;

	// Sequencer: decodes requests and steps the merge.
	smas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_ch.valid),
		.req_type  (in_ch.req_type),
		.req_ready (in_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: lists, comparator, adder and the result registers.
	smas_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.entry_pos   (in_ch.entry_pos),
		.entry_value (in_ch.entry_value),
		.word_valid  (out_ch.valid),
		.word_ready  (out_ch.ready),
		.out_pos     (out_ch.out_pos),
		.out_value   (out_ch.out_value),
		.out_valid   (out_ch.out_valid),
		.out_last    (out_ch.out_last)
	);

endmodule

>>> sim/tb_sparse_matrix_add_sub.sv
// ----------------------------------------------------------------------------
// tb_sparse_matrix_add_sub: self-checking bench for the sparse matrix add/sub
// Loads entry lists, requests sums and differences, and checks every result
// word against an in-bench merge of the same lists. It runs a directed
// opening and then randomized load/emit sequences under changing flow control.
// ----------------------------------------------------------------------------
module tb_sparse_matrix_add_sub;

	import smas_pkg::*;

	// Request codes past REQ_CLEAR are unused and must be ignored.
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_CODE_MAX  = 3'd7;

	localparam int CAP           = CAPACITY_DEF;
	localparam int TARGET_WORDS  = 410;
	localparam int PHASE_LEN     = 50;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 200;

	// Flow-control phases, cycled as the request queue is built.
	typedef enum int {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_t;

	// One request word waiting to be driven. A word marked hold is not
	// presented until every result predicted so far has come back.
	typedef struct {
		logic [REQ_W-1:0]   req;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
		phase_t             phase;
		bit                 hold;
	} request_word_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic               last;
	} merged_entry_t;

	logic clk;
	logic arst_n;

	smas_in_if  req_ch();
	smas_out_if res_ch();

	sparse_matrix_add_sub dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch.sink),
		.out_ch (res_ch.source)
	);

	// Request words still to be driven, filled once at time zero.
	request_word_t pending_words[$];
	request_word_t next_word;
	phase_t        gen_phase;
	phase_t        cur_phase;
	bit            hold_next;
	int            n_queued;

	// The bench's own copy of both entry lists.
	logic [POS_W-1:0]   a_pos[CAP];
	logic [VALUE_W-1:0] a_value[CAP];
	logic [POS_W-1:0]   b_pos[CAP];
	logic [VALUE_W-1:0] b_value[CAP];
	int                 a_count;
	int                 b_count;

	// Every result word predicted so far, in order. The monitor walks it with
	// its own index, so entries are never removed. merged_total is a registered
	// copy of the queue size so that the monitor never sees a push made in
	// the same time step.
	merged_entry_t merged_entries[$];
	int            merged_total;
	int            rd_cnt;
	int            err_cnt;
	int            quiet_cycles;

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		// Known values on every block input from the first instant.
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.entry_pos = '0;
		req_ch.entry_value = '0;
		res_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------
	function automatic void push_entry(logic [POS_W-1:0] pos, logic [VALUE_W-1:0] value,
		logic valid);
		merged_entry_t e;
		e.pos = pos;
		e.value = value;
		e.valid = valid;
		e.last = 1'b0;
		merged_entries.push_back(e);
	endfunction

	// Builds the merged list exactly as the block streams it: the A pass with
	// one word per matching B entry, then the B entries that match nothing.
	function automatic void merge_lists(bit diff);
		int first;
		bit hit;
		first = merged_entries.size();
		for (int i = 0; i < a_count; i++) begin
			hit = 1'b0;
			for (int j = 0; j < b_count; j++) begin
				if (a_pos[i] == b_pos[j]) begin
					push_entry(a_pos[i], diff ? a_value[i] - b_value[j]
						: a_value[i] + b_value[j], 1'b1);
					hit = 1'b1;
				end
			end
			if (!hit)
				push_entry(a_pos[i], a_value[i], 1'b1);
		end
		for (int j = 0; j < b_count; j++) begin
			hit = 1'b0;
			for (int i = 0; i < a_count; i++)
				if (a_pos[i] == b_pos[j])
					hit = 1'b1;
			if (!hit)
				push_entry(b_pos[j], diff ? {VALUE_W{1'b0}} - b_value[j] : b_value[j],
					1'b1);
		end
		// Both lists empty: a single word that carries no entry.
		if (merged_entries.size() == first)
			push_entry('0, '0, 1'b0);
		merged_entries[merged_entries.size() - 1].last = 1'b1;
	endfunction

	function automatic void apply_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
		logic [VALUE_W-1:0] value);
		case (req)
			REQ_LOAD_A: begin
				// A load into a full list is dropped.
				if (a_count < CAP) begin
					a_pos[a_count] = pos;
					a_value[a_count] = value;
					a_count++;
				end
			end
			REQ_LOAD_B: begin
				if (b_count < CAP) begin
					b_pos[b_count] = pos;
					b_value[b_count] = value;
					b_count++;
				end
			end
			REQ_SUM: merge_lists(1'b0);
			REQ_DIFF: merge_lists(1'b1);
			REQ_CLEAR: begin
				a_count = 0;
				b_count = 0;
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Flow control
	// ------------------------------------------------------------------------
	function automatic int send_gap_pct(phase_t p);
		case (p)
			PH_SEND_IDLE: return 68;
			PH_BOTH: return 7;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(phase_t p);
		case (p)
			PH_RECV_STALL: return 68;
			PH_BOTH: return 7;
			default: return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		$display("ERROR: %s", what);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic queue_word(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
		input logic [VALUE_W-1:0] value);
		request_word_t w;
		w.req = req;
		w.pos = pos;
		w.value = value;
		w.phase = gen_phase;
		w.hold = hold_next;
		hold_next = 1'b0;
		pending_words.push_back(w);
		n_queued++;
	endtask

	// Mostly random values, with a fair share of the values where wrapping
	// and negation go wrong.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(19, 0))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Positions cluster around a base so that matches and duplicates are
	// common; a fifth of them land anywhere.
	function automatic logic [POS_W-1:0] pick_pos(logic [POS_W-1:0] base);
		if ($urandom_range(4, 0) == 0)
			return POS_W'($urandom_range(16'hFFFF, 0));
		return base + POS_W'($urandom_range(3, 0));
	endfunction

	// Mostly small lists keep emits short; now and then a list is filled
	// past its capacity.
	function automatic int pick_len();
		if ($urandom_range(9, 0) < 8)
			return $urandom_range(4, 0);
		return $urandom_range(CAP + 2, 0);
	endfunction

	task automatic queue_sequence();
		int na;
		int nb;
		logic [POS_W-1:0] base;
		na = pick_len();
		nb = pick_len();
		base = POS_W'($urandom_range(16'hFFFF, 0));
		if ($urandom_range(7, 0) == 0)
			hold_next = 1'b1;
		// Usually start from empty lists; sometimes keep appending.
		if ($urandom_range(9, 0) != 0)
			queue_word(REQ_CLEAR, POS_W'($urandom_range(16'hFFFF, 0)), $urandom);
		while (na > 0 || nb > 0) begin
			if (nb == 0 || (na > 0 && $urandom_range(1, 0) == 0)) begin
				queue_word(REQ_LOAD_A, pick_pos(base), pick_value());
				na--;
			end else begin
				queue_word(REQ_LOAD_B, pick_pos(base), pick_value());
				nb--;
			end
		end
		repeat ($urandom_range(2, 1))
			queue_word($urandom_range(1, 0) ? REQ_SUM : REQ_DIFF,
				POS_W'($urandom_range(16'hFFFF, 0)), $urandom);
	endtask

	initial begin
		gen_phase = PH_STEADY;
		hold_next = 1'b0;
		n_queued = 0;

		// Directed opening. Emits with both lists empty.
		queue_word(REQ_SUM, '0, '0);
		queue_word(REQ_DIFF, 16'hFFFF, 32'hFFFF_FFFF);
		// Extreme positions and values, a duplicate A position that matches
		// B, a sum that overflows, and an unmatched B holding the most
		// negative value, whose negation wraps onto itself.
		queue_word(REQ_LOAD_A, 16'h0000, 32'h7FFF_FFFF);
		queue_word(REQ_LOAD_A, 16'hFFFF, 32'h8000_0000);
		queue_word(REQ_LOAD_A, 16'h0000, 32'hFFFF_FFFF);
		queue_word(REQ_LOAD_B, 16'h0000, 32'h0000_0001);
		queue_word(REQ_LOAD_B, 16'hFFFF, 32'h0000_0001);
		queue_word(REQ_LOAD_B, 16'h1234, 32'h8000_0000);
		queue_word(REQ_SUM, '0, '0);
		queue_word(REQ_DIFF, '0, '0);
		// The unused codes go by once all results are home.
		hold_next = 1'b1;
		for (int c = REQ_UNUSED_LO; c <= REQ_CODE_MAX; c++)
			queue_word(REQ_W'(c), 16'hAAAA, 32'h5555_5555);
		queue_word(REQ_CLEAR, '0, '0);
		queue_word(REQ_SUM, '0, '0);
		// B alone, negated by a difference, then A alone.
		queue_word(REQ_LOAD_B, 16'hAAAA, 32'h0000_0005);
		queue_word(REQ_DIFF, '0, '0);
		queue_word(REQ_CLEAR, '0, '0);
		queue_word(REQ_LOAD_A, 16'h5555, 32'hFFFF_FFF9);
		queue_word(REQ_SUM, '0, '0);
		queue_word(REQ_CLEAR, '0, '0);

		// Randomized part: mostly well-formed load/emit sequences, with some
		// single words of any code mixed in.
		hold_next = 1'b1;
		while (n_queued < TARGET_WORDS) begin
			gen_phase = phase_t'((n_queued / PHASE_LEN) % 4);
			if ($urandom_range(99, 0) < 8)
				queue_word(REQ_W'($urandom_range(REQ_CODE_MAX, 0)),
					POS_W'($urandom_range(16'hFFFF, 0)), $urandom);
			else
				queue_sequence();
		end

		// Wait for the queue to drain and every predicted word to arrive,
		// then give the block time to show any stray output.
		@(posedge clk);
		while (pending_words.size() != 0 || req_ch.valid || rd_cnt != merged_total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rd_cnt != merged_total)
			report_mismatch($sformatf("%0d result words never arrived",
				merged_total - rd_cnt));
		if (err_cnt == 0)
			$display("PASS sparse_matrix_add_sub");
		else
			$display("FAIL sparse_matrix_add_sub");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	// A word is predicted at the edge where it is accepted. The next word is
	// offered only when the channel is free, a held word waits for the
	// results to catch up, and the current phase may insert a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			cur_phase <= PH_STEADY;
			merged_total <= 0;
			a_count = 0;
			b_count = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_request(req_ch.req_type, req_ch.entry_pos, req_ch.entry_value);
			merged_total <= merged_entries.size();
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_words.size() != 0
						&& (!pending_words[0].hold || rd_cnt == merged_entries.size())
						&& $urandom_range(99, 0) >= send_gap_pct(pending_words[0].phase)) begin
					next_word = pending_words.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.req_type <= next_word.req;
					req_ch.entry_pos <= next_word.pos;
					req_ch.entry_value <= next_word.value;
					cur_phase <= next_word.phase;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------
	// Each accepted word is compared with the oldest prediction not yet
	// matched. The receiver side stalls as the current phase dictates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rd_cnt <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (rd_cnt >= merged_total) begin
					report_mismatch($sformatf(
						"unexpected word: pos %h value %h valid %b last %b",
						res_ch.out_pos, res_ch.out_value, res_ch.out_valid,
						res_ch.out_last));
				end else begin
					if (res_ch.out_pos !== merged_entries[rd_cnt].pos
							|| res_ch.out_value !== merged_entries[rd_cnt].value
							|| res_ch.out_valid !== merged_entries[rd_cnt].valid
							|| res_ch.out_last !== merged_entries[rd_cnt].last)
						report_mismatch($sformatf(
							"word %0d: got pos %h value %h valid %b last %b, want pos %h value %h valid %b last %b",
							rd_cnt, res_ch.out_pos, res_ch.out_value, res_ch.out_valid,
							res_ch.out_last, merged_entries[rd_cnt].pos,
							merged_entries[rd_cnt].value, merged_entries[rd_cnt].valid,
							merged_entries[rd_cnt].last));
					rd_cnt <= rd_cnt + 1;
				end
			end
			res_ch.ready <= $urandom_range(99, 0) >= recv_stall_pct(cur_phase);
		end
	end

	initial err_cnt = 0;

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	// Counts cycles in which neither channel moves a word; a hung block ends
	// the run here.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL sparse_matrix_add_sub");
				$finish;
			end
		end
	end

endmodule

>>> sparse_matrix_add_sub.f
rtl/core/smas_pkg.sv
rtl/core/smas_if.sv
rtl/core/smas_ctrl.sv
rtl/core/smas_dp.sv
rtl/core/sparse_matrix_add_sub.sv
sim/tb_sparse_matrix_add_sub.sv
